### hw/rtl/srrt_pkg.sv
package srrt_pkg;

  // field widths fixed by the item formats
  localparam int OFF_W  = 62;
  localparam int TAG_W  = 16;
  localparam int POS_W  = 6;
  localparam int STS_W  = 3;
  localparam int CMD_W  = 2;
  localparam int MFC_W  = 6;
  localparam int MAS_W  = 16;
  localparam int IN_W   = 208;
  localparam int OUT_W  = 216;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DROP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd3;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STS_W-1:0] STS_FRAG     = 3'd1;
  localparam logic [STS_W-1:0] STS_BAD_DROP = 3'd2;
  localparam logic [STS_W-1:0] STS_NONE     = 3'd3;
  localparam logic [STS_W-1:0] STS_LOCKED   = 3'd4;

  // register indexes
  localparam logic REG_MIN_FRAG = 1'b0;
  localparam logic REG_MIN_SPAN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAIL,
    ST_SCAN_I,
    ST_SCAN_J,
    ST_MOVE,
    ST_PUT,
    ST_PK1,
    ST_PK2,
    ST_DONE
  } srrt_state_t;

endpackage

### hw/rtl/stream_range_reassembly_table.sv
// Channel  | Dir | Contents
// in_      | in  | tdata: range_start, range_end, payload_tag, drop_limit, iter_position;
//          |     | tuser: cmd; tlast: fin_in
// out_     | out | tdata: run_start, run_end, run_tag, run_skip, next_position,
//          |     | entry_count, locked_flag; tuser: status; tlast: fin_out
// cfg_     | in  | APB registers: 0x0 min_fragment_count, 0x4 min_average_span
//
// One item at a time. Each entry is scanned or moved once, through the single read port.
// Reset is synchronous; the entry memory needs no clearing, the held count bounds reads.
// A new item is taken while the previous result still waits in the output register;
// the block holds in its done state only if a second result is ready before that.
module stream_range_reassembly_table #(
  parameter int MAX_ENTRIES = 32,
  parameter int TAG_BITS    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // range_start[61:0], range_end[123:62], payload_tag[139:124],
  // drop_limit[201:140], iter_position[207:202]
  input  logic [srrt_pkg::IN_W-1:0]  in_tdata,
  input  logic [srrt_pkg::CMD_W-1:0] in_tuser,   // cmd
  input  logic                       in_tlast,   // fin_in
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // run_start[61:0], run_end[123:62], run_tag[139:124], run_skip[201:140],
  // next_position[207:202], entry_count[213:208], locked_flag[214], zero[215]
  output logic [srrt_pkg::OUT_W-1:0] out_tdata,
  output logic [srrt_pkg::STS_W-1:0] out_tuser,  // status
  output logic                       out_tlast,  // fin_out
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import srrt_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > MFC_W) ? CW : MFC_W;
  localparam int PW = CW + MAS_W;

  // entry memory
  logic [OFF_W-1:0]    mem_s [MAX_ENTRIES];
  logic [OFF_W-1:0]    mem_e [MAX_ENTRIES];
  logic [TAG_BITS-1:0] mem_t [MAX_ENTRIES];
  logic [OFF_W-1:0]    rd_s_r, rd_e_r;
  logic [TAG_BITS-1:0] rd_t_r;
  logic [AW-1:0]       raddr, waddr;
  logic                we;
  logic [OFF_W-1:0]    wd_s, wd_e;
  logic [TAG_BITS-1:0] wd_t;

  srrt_state_t state_r, state_nxt;

  logic [MFC_W-1:0] mfc_r;
  logic [MAS_W-1:0] mas_r;
  logic [CW-1:0]    held_r, held_nxt;
  logic [OFF_W-1:0] ro_r, ro_nxt;
  logic             fs_r, fs_nxt;
  logic             lock_r, lock_nxt;

  // item being worked on
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [OFF_W-1:0]    s_r, s_nxt;
  logic [OFF_W-1:0]    e_r, e_nxt;       // range end, or drop limit
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                fin_r, fin_nxt;
  logic [CW-1:0]       k_r, k_nxt;       // scan / move / peek index
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       d_r, d_nxt;       // downward move distance
  logic                up_r, up_nxt;
  logic                put_r, put_nxt;
  logic [CW-1:0]       mlast_r, mlast_nxt;
  logic [OFF_W-1:0]    prev_e_r, prev_e_nxt;
  logic [OFF_W-1:0]    te_r, te_nxt;
  logic [OFF_W-1:0]    st_r, st_nxt;

  // pending result
  logic [STS_W-1:0] res_sts_r, res_sts_nxt;
  logic [OFF_W-1:0] res_rs_r, res_rs_nxt;
  logic [OFF_W-1:0] res_re_r, res_re_nxt;
  logic [TAG_W-1:0] res_tag_r, res_tag_nxt;
  logic [OFF_W-1:0] res_skip_r, res_skip_nxt;
  logic             res_fin_r, res_fin_nxt;
  logic [POS_W-1:0] res_np_r, res_np_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [STS_W-1:0] out_sts_r, out_sts_nxt;
  logic             out_fin_r, out_fin_nxt;

  // input fields
  logic [OFF_W-1:0] in_start, in_end, in_lim;
  logic [TAG_W-1:0] in_tag;
  logic [POS_W-1:0] in_pos;
  assign in_start = in_tdata[61:0];
  assign in_end   = in_tdata[123:62];
  assign in_tag   = in_tdata[139:124];
  assign in_lim   = in_tdata[201:140];
  assign in_pos   = in_tdata[207:202];

  // fragmentation check, shared by append and ordered insert
  logic [CW-1:0]    frag_n;
  logic [OFF_W-1:0] frag_tail;
  logic             frag_has;
  logic [OFF_W-1:0] frag_endx, frag_span;
  logic [PW-1:0]    frag_prod;
  logic             refuse;

  always_comb begin
    frag_endx = (frag_has && frag_tail > e_r) ? frag_tail : e_r;
    frag_span = frag_endx - ro_r;
    frag_prod = PW'(frag_n) * PW'(mas_r);
    if (frag_n >= CW'(MAX_ENTRIES)) begin
      refuse = 1'b1;
    end else if (XW'(frag_n) < XW'(mfc_r)) begin
      refuse = 1'b0;
    end else begin
      refuse = OFF_W'(frag_prod) > frag_span;
    end
  end

  // configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mfc_r <= MFC_W'(8);
      mas_r <= MAS_W'(32);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MIN_FRAG: mfc_r <= cfg_pwdata[MFC_W-1:0];
        REG_MIN_SPAN: mas_r <= cfg_pwdata[MAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MIN_FRAG: cfg_prdata = {{(32-MFC_W){1'b0}}, mfc_r};
      REG_MIN_SPAN: cfg_prdata = {{(32-MAS_W){1'b0}}, mas_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[waddr] <= wd_s;
      mem_e[waddr] <= wd_e;
      mem_t[waddr] <= wd_t;
    end
    rd_s_r <= mem_s[raddr];
    rd_e_r <= mem_e[raddr];
    rd_t_r <= mem_t[raddr];
  end

  // sequencer
  logic          accept;
  logic [CW-1:0] pk_k;
  logic          scan_go;
  logic          jin;
  logic [CW-1:0] dj, newcnt;
  logic          skip, put_c;
  logic          mv_up;
  logic [CW-1:0] mv_dn;
  logic          pk_bad;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    ro_nxt       = ro_r;
    fs_nxt       = fs_r;
    lock_nxt     = lock_r;
    cmd_nxt      = cmd_r;
    s_nxt        = s_r;
    e_nxt        = e_r;
    tag_nxt      = tag_r;
    fin_nxt      = fin_r;
    k_nxt        = k_r;
    i_nxt        = i_r;
    d_nxt        = d_r;
    up_nxt       = up_r;
    put_nxt      = put_r;
    mlast_nxt    = mlast_r;
    prev_e_nxt   = prev_e_r;
    te_nxt       = te_r;
    st_nxt       = st_r;
    res_sts_nxt  = res_sts_r;
    res_rs_nxt   = res_rs_r;
    res_re_nxt   = res_re_r;
    res_tag_nxt  = res_tag_r;
    res_skip_nxt = res_skip_r;
    res_fin_nxt  = res_fin_r;
    res_np_nxt   = res_np_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt = out_data_r;
    out_sts_nxt  = out_sts_r;
    out_fin_nxt  = out_fin_r;
    raddr        = '0;
    we           = 1'b0;
    waddr        = '0;
    wd_s         = s_r;
    wd_e         = e_r;
    wd_t         = tag_r;
    frag_n       = held_r;
    frag_tail    = rd_e_r;
    frag_has     = 1'b1;

    pk_k    = (XW'(in_pos) > XW'(held_r)) ? held_r : CW'(in_pos);
    scan_go = (k_r < held_r) && (rd_s_r < s_r);
    jin     = (k_r < held_r);
    dj      = k_r - i_r;
    newcnt  = held_r - dj;
    skip    = (i_r != '0) && jin && (rd_s_r <= prev_e_r);
    put_c   = 1'b0;
    mv_up   = 1'b0;
    mv_dn   = dj;
    pk_bad  = (k_r >= held_r) || (rd_s_r > st_r) || (st_r >= rd_e_r);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_tuser;
          s_nxt        = in_start;
          e_nxt        = (in_tuser == CMD_DROP) ? in_lim : in_end;
          tag_nxt      = TAG_BITS'(in_tag);
          fin_nxt      = in_tlast;
          res_sts_nxt  = STS_OK;
          res_rs_nxt   = '0;
          res_re_nxt   = '0;
          res_tag_nxt  = '0;
          res_skip_nxt = '0;
          res_fin_nxt  = 1'b0;
          res_np_nxt   = '0;
          raddr        = AW'(held_r - CW'(1));
          case (in_tuser)
            CMD_INSERT: begin
              if (ro_r >= in_end) begin
                fs_nxt    = fs_r | in_tlast;
                state_nxt = ST_DONE;
              end else if (held_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wd_s      = in_start;
                wd_e      = in_end;
                wd_t      = TAG_BITS'(in_tag);
                held_nxt  = CW'(1);
                fs_nxt    = fs_r | in_tlast;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_TAIL;
              end
            end
            CMD_DROP: begin
              if (held_r == '0) begin
                if (in_lim != ro_r) begin
                  res_sts_nxt = STS_BAD_DROP;
                end else begin
                  lock_nxt = 1'b0;
                end
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_TAIL;
              end
            end
            default: begin
              if (in_tuser == CMD_LOCK && lock_r) begin
                res_sts_nxt = STS_LOCKED;
                state_nxt   = ST_DONE;
              end else begin
                k_nxt = (in_tuser == CMD_LOCK) ? '0 : pk_k;
                if (in_tuser == CMD_LOCK || pk_k == '0) begin
                  st_nxt    = ro_r;
                  raddr     = '0;
                  state_nxt = ST_PK2;
                end else begin
                  raddr     = AW'(pk_k - CW'(1));
                  state_nxt = ST_PK1;
                end
              end
            end
          endcase
        end
      end

      // tail entry is in the read register
      ST_TAIL: begin
        te_nxt = rd_e_r;
        if (cmd_r == CMD_DROP) begin
          if (e_r < ro_r || e_r > rd_e_r) begin
            res_sts_nxt = STS_BAD_DROP;
            state_nxt   = ST_DONE;
          end else begin
            ro_nxt    = e_r;
            lock_nxt  = 1'b0;
            i_nxt     = '0;
            k_nxt     = '0;
            raddr     = '0;
            state_nxt = ST_SCAN_J;
          end
        end else if (rd_s_r < s_r) begin
          if (rd_e_r >= e_r) begin
            fs_nxt    = fs_r | fin_r;
            state_nxt = ST_DONE;
          end else if (refuse) begin
            res_sts_nxt = STS_FRAG;
            state_nxt   = ST_DONE;
          end else begin
            we        = 1'b1;
            waddr     = AW'(held_r);
            held_nxt  = held_r + CW'(1);
            fs_nxt    = fs_r | fin_r;
            state_nxt = ST_DONE;
          end
        end else begin
          k_nxt      = '0;
          raddr      = '0;
          state_nxt  = ST_SCAN_I;
        end
      end

      // first entry whose start is not below the new start
      ST_SCAN_I: begin
        if (scan_go) begin
          prev_e_nxt = rd_e_r;
          k_nxt      = k_r + CW'(1);
          raddr      = AW'(k_r + CW'(1));
        end else begin
          i_nxt = k_r;
          if (k_r != '0 && prev_e_r >= e_r) begin
            fs_nxt    = fs_r | fin_r;
            state_nxt = ST_DONE;
          end else begin
            raddr     = AW'(k_r);
            state_nxt = ST_SCAN_J;
          end
        end
      end

      // entries wholly covered by the new range, or consumed by a drop
      ST_SCAN_J: begin
        frag_n    = newcnt;
        frag_tail = jin ? te_r : prev_e_r;
        frag_has  = jin || (i_r != '0);
        if (jin && rd_e_r <= e_r) begin
          k_nxt = k_r + CW'(1);
          raddr = AW'(k_r + CW'(1));
        end else begin
          if (cmd_r == CMD_INSERT) begin
            if (skip) begin
              fs_nxt = fs_r | fin_r;
            end else if (refuse) begin
              res_sts_nxt = STS_FRAG;
            end else begin
              put_c  = 1'b1;
              fs_nxt = fs_r | fin_r;
            end
          end
          mv_up     = put_c && (dj == '0);
          mv_dn     = put_c ? dj - CW'(1) : dj;
          put_nxt   = put_c;
          up_nxt    = mv_up;
          d_nxt     = mv_dn;
          held_nxt  = newcnt + CW'(put_c);
          if (jin && (mv_up || mv_dn != '0)) begin
            k_nxt     = mv_up ? held_r - CW'(1) : k_r;
            mlast_nxt = mv_up ? k_r : held_r - CW'(1);
            raddr     = mv_up ? AW'(held_r - CW'(1)) : AW'(k_r);
            state_nxt = ST_MOVE;
          end else begin
            state_nxt = put_c ? ST_PUT : ST_DONE;
          end
        end
      end

      // shift the surviving tail one entry per cycle
      ST_MOVE: begin
        we    = 1'b1;
        waddr = up_r ? AW'(k_r + CW'(1)) : AW'(k_r - d_r);
        wd_s  = rd_s_r;
        wd_e  = rd_e_r;
        wd_t  = rd_t_r;
        if (k_r == mlast_r) begin
          state_nxt = put_r ? ST_PUT : ST_DONE;
        end else begin
          k_nxt = up_r ? k_r - CW'(1) : k_r + CW'(1);
          raddr = up_r ? AW'(k_r - CW'(1)) : AW'(k_r + CW'(1));
        end
      end

      ST_PUT: begin
        we        = 1'b1;
        waddr     = AW'(i_r);
        state_nxt = ST_DONE;
      end

      ST_PK1: begin
        st_nxt    = rd_e_r;
        raddr     = AW'(k_r);
        state_nxt = ST_PK2;
      end

      ST_PK2: begin
        res_rs_nxt = st_r;
        if (pk_bad) begin
          res_sts_nxt = STS_NONE;
          res_re_nxt  = st_r;
          res_fin_nxt = (k_r >= held_r) && fs_r;
        end else begin
          res_re_nxt   = rd_e_r;
          res_tag_nxt  = TAG_W'(rd_t_r);
          res_skip_nxt = st_r - rd_s_r;
          res_fin_nxt  = ((k_r + CW'(1)) == held_r) && fs_r;
          res_np_nxt   = POS_W'(k_r + CW'(1));
          if (cmd_r == CMD_LOCK) begin
            lock_nxt = 1'b1;
          end
        end
        state_nxt = ST_DONE;
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = res_sts_r;
          out_fin_nxt   = res_fin_r;
          out_data_nxt  = {1'b0, lock_r, POS_W'(held_r), res_np_r, res_skip_r,
                           res_tag_r, res_re_r, res_rs_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      ro_r        <= '0;
      fs_r        <= 1'b0;
      lock_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      ro_r        <= ro_nxt;
      fs_r        <= fs_nxt;
      lock_r      <= lock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    tag_r      <= tag_nxt;
    fin_r      <= fin_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    d_r        <= d_nxt;
    up_r       <= up_nxt;
    put_r      <= put_nxt;
    mlast_r    <= mlast_nxt;
    prev_e_r   <= prev_e_nxt;
    te_r       <= te_nxt;
    st_r       <= st_nxt;
    res_sts_r  <= res_sts_nxt;
    res_rs_r   <= res_rs_nxt;
    res_re_r   <= res_re_nxt;
    res_tag_r  <= res_tag_nxt;
    res_skip_r <= res_skip_nxt;
    res_fin_r  <= res_fin_nxt;
    res_np_r   <= res_np_nxt;
    out_data_r <= out_data_nxt;
    out_sts_r  <= out_sts_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sts_r;
  assign out_tlast  = out_fin_r;

  // checks
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(MAX_ENTRIES))
    else $error("held count above table depth");

  a_move_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> (waddr != raddr) || (k_r == mlast_r))
    else $error("move writes the entry being read");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second item taken while one is in work");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !accept) |=> $stable(held_r))
    else $error("entry count changed while idle");

  a_offset_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> ro_r >= $past(ro_r))
    else $error("read offset moved back");

endmodule

### bench/srrt_checker.sv
`timescale 1ns / 100ps

// Watches the item channels and the register port, predicts each result from its
// own copy of the range table and compares it field by field.
module srrt_checker
  import srrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic [CMD_W-1:0]  in_tuser,
  input  logic              in_tlast,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic [STS_W-1:0]  out_tuser,
  input  logic              out_tlast,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output logic [OFF_W-1:0]  cur_offset,
  output logic [OFF_W-1:0]  tail_end,
  output int                held
);

  localparam int DEPTH = 32;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [OFF_W-1:0] run_start;
    logic [OFF_W-1:0] run_end;
    logic [TAG_W-1:0] run_tag;
    logic [OFF_W-1:0] run_skip;
    logic             fin;
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] count;
    logic             locked;
  } run_rec_t;

  // table copy
  logic [OFF_W-1:0] tbl_start [DEPTH];
  logic [OFF_W-1:0] tbl_end   [DEPTH];
  logic [TAG_W-1:0] tbl_tag   [DEPTH];
  int               n_held;
  logic [OFF_W-1:0] rd_off;
  bit               fin_seen;
  bit               lock_taken;
  logic [MFC_W-1:0] min_frag;
  logic [MAS_W-1:0] min_span;

  run_rec_t expected_runs[$];

  function automatic bit too_fragmented(logic [OFF_W-1:0] e);
    logic [OFF_W-1:0] span;
    if (n_held >= DEPTH) return 1'b1;
    if (n_held < int'(min_frag)) return 1'b0;
    if (n_held > 0 && tbl_end[n_held-1] > e) e = tbl_end[n_held-1];
    span = e - rd_off;
    return (64'(n_held) * 64'(min_span)) > 64'(span);
  endfunction

  function automatic void cut_entries(int lo, int hi);
    int d;
    d = hi - lo;
    if (hi <= lo) return;
    for (int k = lo; k < n_held - d; k++) begin
      tbl_start[k] = tbl_start[k+d];
      tbl_end[k]   = tbl_end[k+d];
      tbl_tag[k]   = tbl_tag[k+d];
    end
    n_held -= d;
  endfunction

  function automatic void place_entry(int pos, logic [OFF_W-1:0] s, logic [OFF_W-1:0] e,
                                      logic [TAG_W-1:0] t);
    if (n_held >= DEPTH || pos > n_held) return;
    for (int k = n_held; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_end[k]   = tbl_end[k-1];
      tbl_tag[k]   = tbl_tag[k-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos]   = e;
    tbl_tag[pos]   = t;
    n_held++;
  endfunction

  function automatic logic [STS_W-1:0] add_range(logic [OFF_W-1:0] s, logic [OFF_W-1:0] e,
                                                 logic [TAG_W-1:0] t);
    int i, j;
    if (rd_off >= e) return STS_OK;
    if (n_held == 0) begin
      place_entry(0, s, e, t);
      return STS_OK;
    end
    // beyond every held start: append unless already covered
    if (tbl_start[n_held-1] < s) begin
      if (tbl_end[n_held-1] >= e) return STS_OK;
      if (too_fragmented(e)) return STS_FRAG;
      place_entry(n_held, s, e, t);
      return STS_OK;
    end
    i = 0;
    while (i < n_held && tbl_start[i] < s) i++;
    if (i > 0 && tbl_end[i-1] >= e) return STS_OK;
    j = i;
    while (j < n_held && tbl_end[j] <= e) j++;
    cut_entries(i, j);
    if (i > 0 && i < n_held && tbl_start[i] <= tbl_end[i-1]) return STS_OK;
    if (too_fragmented(e)) return STS_FRAG;
    place_entry(i, s, e, t);
    return STS_OK;
  endfunction

  function automatic logic [STS_W-1:0] find_run(int pos, ref run_rec_t r);
    int k;
    logic [OFF_W-1:0] from;
    k = (pos > n_held) ? n_held : pos;
    from = (k == 0) ? rd_off : tbl_end[k-1];
    r.run_start = from;
    if (k >= n_held || tbl_start[k] > from || from >= tbl_end[k]) begin
      r.run_end = from;
      r.fin = (k >= n_held) && fin_seen;
      return STS_NONE;
    end
    r.run_end  = tbl_end[k];
    r.run_tag  = tbl_tag[k];
    r.run_skip = from - tbl_start[k];
    r.fin      = (k + 1 == n_held) && fin_seen;
    r.next_pos = POS_W'(k + 1);
    return STS_OK;
  endfunction

  function automatic run_rec_t apply_command(logic [CMD_W-1:0] cmd, logic [IN_W-1:0] d,
                                             logic fin_in);
    run_rec_t r;
    logic [OFF_W-1:0] lim;
    int n;
    r = '{default: '0};
    lim = d[201:140];
    case (cmd)
      CMD_INSERT: begin
        r.status = add_range(d[61:0], d[123:62], d[139:124]);
        if (r.status == STS_OK && fin_in) fin_seen = 1'b1;
      end
      CMD_DROP: begin
        if (lim < rd_off || (n_held > 0 && lim > tbl_end[n_held-1]) ||
            (n_held == 0 && lim != rd_off)) begin
          r.status = STS_BAD_DROP;
        end else begin
          rd_off = lim;
          n = 0;
          while (n < n_held && tbl_end[n] <= lim) n++;
          cut_entries(0, n);
          lock_taken = 1'b0;
        end
      end
      CMD_PEEK: r.status = find_run(int'(d[207:202]), r);
      default: begin
        if (lock_taken) begin
          r.status = STS_LOCKED;
        end else begin
          r.status = find_run(0, r);
          if (r.status == STS_OK) lock_taken = 1'b1;
        end
      end
    endcase
    r.count  = POS_W'(n_held);
    r.locked = lock_taken;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // compare the oldest expectation first, then predict the newly accepted item
  always @(posedge clk) begin
    run_rec_t e;
    if (!rst_n) begin
      n_held      = 0;
      rd_off      = '0;
      fin_seen    = 1'b0;
      lock_taken  = 1'b0;
      min_frag    = 6'd8;
      min_span    = 16'd32;
      expected_runs.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_runs.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          e = expected_runs.pop_front();
          check_field("status", e.status, out_tuser);
          check_field("run_start", e.run_start, out_tdata[61:0]);
          check_field("run_end", e.run_end, out_tdata[123:62]);
          check_field("run_tag", e.run_tag, out_tdata[139:124]);
          check_field("run_skip", e.run_skip, out_tdata[201:140]);
          check_field("next_position", e.next_pos, out_tdata[207:202]);
          check_field("entry_count", e.count, out_tdata[213:208]);
          check_field("locked_flag", e.locked, out_tdata[214]);
          check_field("pad", 0, out_tdata[215]);
          check_field("fin_out", e.fin, out_tlast);
        end
      end
      if (in_tvalid && in_tready)
        expected_runs.push_back(apply_command(in_tuser, in_tdata, in_tlast));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_MIN_FRAG) min_frag = cfg_pwdata[MFC_W-1:0];
        else min_span = cfg_pwdata[MAS_W-1:0];
      end
    end
    pending    = expected_runs.size();
    held       = n_held;
    cur_offset = rd_off;
    tail_end   = (n_held > 0) ? tbl_end[n_held-1] : rd_off;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import srrt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 150;

  logic              clk;
  logic              rst_n;
  logic [IN_W-1:0]   in_tdata;
  logic [CMD_W-1:0]  in_tuser;
  logic              in_tlast;
  logic              in_tvalid;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic [STS_W-1:0]  out_tuser;
  logic              out_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [2:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int               fail_count;
  int               pending;
  int               results_seen;
  logic [OFF_W-1:0] cur_offset;
  logic [OFF_W-1:0] tail_end;
  int               held;

  int send_gap;     // percent of cycles the sender idles
  int recv_stall;   // percent of cycles the receiver stalls
  int idle_count;
  int n_sent;
  int n_cmd [4];

  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  stream_range_reassembly_table u_dut (.*);

  srrt_checker u_chk (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver back-pressure
  always @(negedge clk)
    out_tready = ($urandom_range(0, 99) >= recv_stall);

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  function automatic logic [OFF_W-1:0] rand_off();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[OFF_W-1:0];
  endfunction

  // one item; entered and left at a falling edge
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [OFF_W-1:0] s, logic [OFF_W-1:0] e,
                           logic [TAG_W-1:0] tag, logic fin, logic [OFF_W-1:0] lim,
                           logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_gap) @(negedge clk);
    in_tdata  = {pos, lim, tag, e, s};
    in_tuser  = cmd;
    in_tlast  = fin;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    n_sent++;
    n_cmd[cmd]++;
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = value;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // settle the block, then load both registers
  task automatic set_config(logic [MFC_W-1:0] frag, logic [MAS_W-1:0] span);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    write_reg({REG_MIN_FRAG, 2'b00}, 32'(frag));
    write_reg({REG_MIN_SPAN, 2'b00}, 32'(span));
  endtask

  // random item, mostly ranges near the read window with some noise
  task automatic random_item();
    logic [OFF_W-1:0] base, s, e, lim, gap;
    int sel;
    int unsigned reach;
    gap   = tail_end - cur_offset;
    reach = (gap > 2000) ? 2000 : int'(gap);
    base  = (cur_offset >= 20) ? cur_offset - 20 : '0;
    sel   = $urandom_range(0, 99);
    s     = base + $urandom_range(0, reach + 150);
    e     = s + $urandom_range(1, 60);
    lim   = cur_offset + $urandom_range(0, reach);
    if (sel < 45) begin
      if ($urandom_range(0, 99) < 4) e = s - $urandom_range(0, 10);
      send_item(CMD_INSERT, s, e, 16'($urandom), $urandom_range(0, 99) < 5,
                rand_off(), 6'($urandom));
    end else if (sel < 60) begin
      if ($urandom_range(0, 99) < 20) lim = cur_offset + $urandom_range(0, reach + 40) - 20;
      send_item(CMD_DROP, rand_off(), rand_off(), 16'($urandom), 1'($urandom), lim,
                6'($urandom));
    end else if (sel < 85) begin
      send_item(CMD_PEEK, rand_off(), rand_off(), 16'($urandom), 1'($urandom), rand_off(),
                6'($urandom_range(0, held + 2)));
    end else if (sel < 95) begin
      send_item(CMD_LOCK, rand_off(), rand_off(), 16'($urandom), 1'($urandom), rand_off(),
                6'($urandom));
    end else begin
      send_item(CMD_W'($urandom), rand_off(), rand_off(), 16'($urandom), 1'($urandom),
                rand_off(), 6'($urandom));
    end
  endtask

  initial begin
    logic [MFC_W-1:0] frag_set [5];
    logic [MAS_W-1:0] span_set [5];
    int gap_set  [4];
    int stall_set[4];
    frag_set    = '{6'd8, 6'd0, 6'd32, 6'd3, 6'd0};
    span_set    = '{16'd32, 16'hFFFF, 16'd0, 16'd16, 16'd0};
    gap_set     = '{0, 83, 0, 31};
    stall_set   = '{0, 0, 83, 31};
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_INSERT;
    in_tlast    = 1'b0;
    in_tvalid   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    send_gap    = 0;
    recv_stall  = 0;
    n_sent      = 0;
    n_cmd       = '{default: 0};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, placement rules, cursor and lock cases, bad drops
    send_item(CMD_PEEK,   '0, '0, '0, 1'b0, '0, 6'd0);
    send_item(CMD_LOCK,   '0, '0, '0, 1'b0, '0, '0);
    send_item(CMD_DROP,   '0, '0, '0, 1'b0, 62'd5, '0);
    send_item(CMD_DROP,   '0, '0, '0, 1'b0, 62'd0, '0);
    send_item(CMD_INSERT, 62'd100, 62'd200, 16'hFFFF, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd300, 62'd400, 16'h0001, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd150, 62'd180, 16'h0002, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd50,  62'd120, 16'h0003, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd0,   62'd500, 16'h0004, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd600, 62'd700, 16'h0005, 1'b1, '0, '0);
    send_item(CMD_PEEK,   '0, '0, '0, 1'b0, '0, 6'd0);
    send_item(CMD_PEEK,   '0, '0, '0, 1'b0, '0, 6'd1);
    send_item(CMD_PEEK,   OFF_MAX, OFF_MAX, '1, 1'b1, OFF_MAX, 6'd63);
    send_item(CMD_LOCK,   '0, '0, '0, 1'b0, '0, '0);
    send_item(CMD_LOCK,   '0, '0, '0, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd0,   62'd550, 16'h0006, 1'b0, '0, '0);
    send_item(CMD_DROP,   '0, '0, '0, 1'b0, 62'd800, '0);
    send_item(CMD_DROP,   '0, '0, '0, 1'b0, 62'd520, '0);
    send_item(CMD_DROP,   '0, '0, '0, 1'b0, 62'd10, '0);
    send_item(CMD_INSERT, 62'd10,  62'd20,  16'h0007, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd900, 62'd850, 16'h0008, 1'b0, '0, '0);
    send_item(CMD_INSERT, 62'd1000, 62'd1000, 16'h0009, 1'b0, '0, '0);
    send_item(CMD_INSERT, OFF_MAX, OFF_MAX, 16'hFFFF, 1'b1, '0, '0);
    send_item(CMD_INSERT, '0, OFF_MAX, '0, 1'b0, '0, '0);
    send_item(CMD_DROP,   '0, '0, '0, 1'b0, OFF_MAX, '0);

    // random phases, each with its own register setting and one of four idling patterns
    for (int p = 0; p < 5; p++) begin
      set_config(frag_set[p], span_set[p]);
      send_gap   = gap_set[p % 4];
      recv_stall = stall_set[p % 4];
      repeat (PHASE_ITEMS) random_item();
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d items (insert %0d, drop %0d, peek %0d, lock %0d), %0d results checked,",
             n_sent, n_cmd[CMD_INSERT], n_cmd[CMD_DROP], n_cmd[CMD_PEEK], n_cmd[CMD_LOCK],
             results_seen);
    $display("over five register settings and four idling patterns.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
